// File: rtl/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// Shared types, constants and the arctangent table for the motion classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package amc_pkg;

    localparam int SQRT_STEPS  = 31;
    localparam int CORDIC_STEPS = 24;

    localparam logic [20:0] ONE_G    = 21'd16384;
    localparam logic [19:0] MAG_MAX  = 20'hFFFFF;
    localparam logic [13:0] TILT_MAX = 14'd11520;
    localparam logic signed [31:0] DEG90_UNITS = 32'sd377487360;

    typedef enum logic [2:0] {
        CFG_RANGE    = 3'd0,
        CFG_OFFSET_X = 3'd1,
        CFG_OFFSET_Y = 3'd2,
        CFG_OFFSET_Z = 3'd3,
        CFG_MOVING   = 3'd4,
        CFG_IMPACT   = 3'd5,
        CFG_TILT     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [20:0]        mag;
        logic               moving;
        logic               impact;
        logic signed [20:0] cz;
    } t_side;

    typedef struct packed {
        logic [61:0] val;
        logic [33:0] rem;
        logic [30:0] root;
        t_side       side;
    } t_sq;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [31:0] acc;
        t_side              side;
    } t_cd;

    function automatic logic signed [31:0] atan_units(input logic [4:0] step);
        logic signed [31:0] v;
        case (step)
            5'd0:  v = 32'sd188743680;
            5'd1:  v = 32'sd111421900;
            5'd2:  v = 32'sd58872272;
            5'd3:  v = 32'sd29884485;
            5'd4:  v = 32'sd15000234;
            5'd5:  v = 32'sd7507429;
            5'd6:  v = 32'sd3754631;
            5'd7:  v = 32'sd1877430;
            5'd8:  v = 32'sd938729;
            5'd9:  v = 32'sd469366;
            5'd10: v = 32'sd234683;
            5'd11: v = 32'sd117342;
            5'd12: v = 32'sd58671;
            5'd13: v = 32'sd29335;
            5'd14: v = 32'sd14668;
            5'd15: v = 32'sd7334;
            5'd16: v = 32'sd3667;
            5'd17: v = 32'sd1833;
            5'd18: v = 32'sd917;
            5'd19: v = 32'sd458;
            5'd20: v = 32'sd229;
            5'd21: v = 32'sd115;
            5'd22: v = 32'sd57;
            5'd23: v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/amc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// amc_sqrt_cell
// One digit step of the integer square root: two radicand bits, one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_sqrt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  amc_pkg::t_sq       i_data,
    output logic               o_valid,
    output amc_pkg::t_sq       o_data
);
    import amc_pkg::*;

    logic [33:0] rem2;
    logic [33:0] trial;
    t_sq         n_data;
    logic        r_valid;
    t_sq         r_data;

    always_comb begin
        rem2   = {i_data.rem[31:0], i_data.val[61:60]};
        trial  = {1'b0, i_data.root, 2'b01};
        n_data = i_data;
        n_data.val = {i_data.val[59:0], 2'b00};
        if (rem2 >= trial) begin
            n_data.rem  = rem2 - trial;
            n_data.root = {i_data.root[29:0], 1'b1};
        end else begin
            n_data.rem  = rem2;
            n_data.root = {i_data.root[29:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/amc_cordic_cell.sv
// ----------------------------------------------------------------------------
// amc_cordic_cell
// One vectoring rotation of the angle search, accumulating the arctangent.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_cordic_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [4:0]    i_step,
    input  wire logic          i_valid,
    input  amc_pkg::t_cd       i_data,
    output logic               o_valid,
    output amc_pkg::t_cd       o_data
);
    import amc_pkg::*;

    logic signed [34:0] sx;
    logic signed [34:0] sy;
    t_cd                n_data;
    logic               r_valid;
    t_cd                r_data;

    always_comb begin
        sx     = i_data.x >>> i_step;
        sy     = i_data.y >>> i_step;
        n_data = i_data;
        if (i_data.y >= 0) begin
            n_data.x   = i_data.x + sy;
            n_data.y   = i_data.y - sx;
            n_data.acc = i_data.acc + atan_units(i_step);
        end else begin
            n_data.x   = i_data.x - sy;
            n_data.y   = i_data.y + sx;
            n_data.acc = i_data.acc - atan_units(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/accel_motion_classifier.sv
// ----------------------------------------------------------------------------
// accel_motion_classifier
// Accelerometer magnitude, motion, impact, tilt and rollover classifier.
//
// Input channel: i_in_valid / o_in_stall with raw x, y, z samples.
// Output channel: o_out_valid / i_out_stall with magnitude, flags and tilt.
// Configuration: i_cfg_valid / o_cfg_ready write beats of index and data;
// o_cfg_ready is always high. Write only while the pipeline is empty.
// Each sample passes a pipeline of three front stages,
// a row of 31 square root cells for the magnitude, two stages, a second
// row of 31 square root cells for the horizontal component, one stage,
// 24 rotation cells for the angle and the output register.
// Without a stall, a sample is accepted and a result leaves every cycle.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_in_stall rises in the same cycle; it drops as soon as the result is
// taken. Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_motion_classifier (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_raw_x,
    input  wire logic signed [15:0] i_raw_y,
    input  wire logic signed [15:0] i_raw_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [19:0]             o_magnitude,
    output logic                    o_moving,
    output logic                    o_impact,
    output logic [19:0]             o_impact_level,
    output logic [13:0]             o_tilt,
    output logic                    o_rollover,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [19:0]        i_cfg_data
);
    import amc_pkg::*;

    logic [1:0]         r_accel_range;
    logic signed [19:0] r_off_x;
    logic signed [19:0] r_off_y;
    logic signed [19:0] r_off_z;
    logic [19:0]        r_moving_limit;
    logic [19:0]        r_impact_limit;
    logic [13:0]        r_tilt_limit;

    logic en;

    logic               r_s0_valid;
    logic signed [20:0] r_cx, r_cy, r_cz;
    logic signed [20:0] n_cx, n_cy, n_cz;

    logic               r_s1_valid;
    logic [39:0]        r_sqx, r_sqy, r_sqz;
    logic signed [20:0] r_s1_cz;
    logic signed [41:0] px, py, pz;

    logic               sq1_valid [SQRT_STEPS+1];
    t_sq                sq1_data  [SQRT_STEPS+1];
    logic               r_s2_valid;
    t_sq                r_s2;

    logic               r_s3_valid;
    t_side              r_s3_side;
    logic [41:0]        r_mm, r_zz;
    logic [20:0]        m1;
    logic [20:0]        dev;
    logic signed [41:0] pzz;

    logic               sq2_valid [SQRT_STEPS+1];
    t_sq                sq2_data  [SQRT_STEPS+1];
    logic               r_s4_valid;
    t_sq                r_s4;

    logic               cd_valid [CORDIC_STEPS+1];
    t_cd                cd_data  [CORDIC_STEPS+1];
    logic               r_s5_valid;
    t_cd                r_s5;
    t_cd                n_s5;
    logic signed [34:0] zz_big;

    logic signed [32:0] acc_r;
    logic [16:0]        tq;
    logic [13:0]        n_tilt;
    t_side              fin;

    assign o_cfg_ready = 1'b1;
    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_range  <= 2'd0;
            r_off_x        <= '0;
            r_off_y        <= '0;
            r_off_z        <= '0;
            r_moving_limit <= 20'd1638;
            r_impact_limit <= 20'd49152;
            r_tilt_limit   <= 14'd2880;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RANGE:    r_accel_range  <= i_cfg_data[1:0];
                CFG_OFFSET_X: r_off_x        <= i_cfg_data;
                CFG_OFFSET_Y: r_off_y        <= i_cfg_data;
                CFG_OFFSET_Z: r_off_z        <= i_cfg_data;
                CFG_MOVING:   r_moving_limit <= i_cfg_data;
                CFG_IMPACT:   r_impact_limit <= i_cfg_data;
                CFG_TILT:     r_tilt_limit   <= i_cfg_data[13:0];
                default:      r_tilt_limit   <= r_tilt_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid  <= i_in_valid;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= sq1_valid[SQRT_STEPS];
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= sq2_valid[SQRT_STEPS];
            o_out_valid <= cd_valid[CORDIC_STEPS];
        end
    end

    // scale and correct
    always_comb begin
        n_cx = (21'(i_raw_x) <<< r_accel_range) - 21'(r_off_x);
        n_cy = (21'(i_raw_y) <<< r_accel_range) - 21'(r_off_y);
        n_cz = (21'(i_raw_z) <<< r_accel_range) - 21'(r_off_z);
        px   = r_cx * r_cx;
        py   = r_cy * r_cy;
        pz   = r_cz * r_cz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_cz    <= n_cz;
            r_sqx   <= px[39:0];
            r_sqy   <= py[39:0];
            r_sqz   <= pz[39:0];
            r_s1_cz <= r_cz;
            r_s2.val       <= {20'd0, 42'(r_sqx) + 42'(r_sqy) + 42'(r_sqz)};
            r_s2.rem       <= '0;
            r_s2.root      <= '0;
            r_s2.side.mag  <= '0;
            r_s2.side.moving <= 1'b0;
            r_s2.side.impact <= 1'b0;
            r_s2.side.cz   <= r_s1_cz;
        end
    end

    assign sq1_valid[0] = r_s2_valid;
    assign sq1_data[0]  = r_s2;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt1
        amc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq1_valid[k]),
            .i_data  (sq1_data[k]),
            .o_valid (sq1_valid[k+1]),
            .o_data  (sq1_data[k+1])
        );
    end

    // magnitude flags and squares for the horizontal component
    always_comb begin
        m1  = sq1_data[SQRT_STEPS].root[20:0];
        dev = (m1 >= ONE_G) ? (m1 - ONE_G) : (ONE_G - m1);
        pzz = sq1_data[SQRT_STEPS].side.cz * sq1_data[SQRT_STEPS].side.cz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_side.mag    <= m1;
            r_s3_side.moving <= dev > 21'(r_moving_limit);
            r_s3_side.impact <= m1 > 21'(r_impact_limit);
            r_s3_side.cz     <= sq1_data[SQRT_STEPS].side.cz;
            r_mm             <= 42'(m1) * 42'(m1);
            r_zz             <= pzz;
            r_s4.val         <= {r_mm - r_zz, 20'd0};
            r_s4.rem         <= '0;
            r_s4.root        <= '0;
            r_s4.side        <= r_s3_side;
        end
    end

    assign sq2_valid[0] = r_s4_valid;
    assign sq2_data[0]  = r_s4;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt2
        amc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq2_valid[k]),
            .i_data  (sq2_data[k]),
            .o_valid (sq2_valid[k+1]),
            .o_data  (sq2_data[k+1])
        );
    end

    // start vector, turned by 90 degrees when z points down
    always_comb begin
        zz_big      = 35'(sq2_data[SQRT_STEPS].side.cz) <<< 10;
        n_s5.side   = sq2_data[SQRT_STEPS].side;
        if (zz_big >= 0) begin
            n_s5.x   = zz_big;
            n_s5.y   = 35'(sq2_data[SQRT_STEPS].root);
            n_s5.acc = '0;
        end else begin
            n_s5.x   = 35'(sq2_data[SQRT_STEPS].root);
            n_s5.y   = -zz_big;
            n_s5.acc = DEG90_UNITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5 <= n_s5;
        end
    end

    assign cd_valid[0] = r_s5_valid;
    assign cd_data[0]  = r_s5;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        amc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (5'(k)),
            .i_valid (cd_valid[k]),
            .i_data  (cd_data[k]),
            .o_valid (cd_valid[k+1]),
            .o_data  (cd_data[k+1])
        );
    end

    // round, clamp and pack the result
    always_comb begin
        fin   = cd_data[CORDIC_STEPS].side;
        acc_r = 33'(cd_data[CORDIC_STEPS].acc);
        if (acc_r < 0) begin
            acc_r = '0;
        end
        acc_r = acc_r + 33'sd32768;
        tq    = acc_r[32:16];
        if (fin.mag == '0) begin
            n_tilt = '0;
        end else if (tq > 17'(TILT_MAX)) begin
            n_tilt = TILT_MAX;
        end else begin
            n_tilt = tq[13:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_magnitude    <= fin.mag[20] ? MAG_MAX : fin.mag[19:0];
            o_moving       <= fin.moving;
            o_impact       <= fin.impact;
            o_impact_level <= !fin.impact ? 20'd0 : (fin.mag[20] ? MAG_MAX : fin.mag[19:0]);
            o_tilt         <= n_tilt;
            o_rollover     <= (fin.mag != '0) && (n_tilt > r_tilt_limit);
        end
    end

endmodule

`default_nettype wire
